// File: hdl/iss_pkg.sv
// Package for the integer stack with search: field widths, request and
// status codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_SEARCH = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_POP,
        S_READ_PEEK,
        S_SCAN
    } t_state;

    // Source of the data and index fields of a result
    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_RDDATA,
        RES_FOUND
    } t_res_sel;

    typedef struct packed {
        logic     capture;     // latch the search target
        logic     ram_wr;      // write the pushed word at the top
        logic     rd_top;      // read the top entry, start the scan index there
        logic     rd_next;     // read the entry below the scan index
        logic     count_inc;
        logic     count_dec;
        logic     count_clr;
        logic     res_load;
        t_res_sel res_sel;
        t_status  res_status;
    } t_cmd;

    typedef struct packed {
        logic empty;    // no entries held
        logic full;     // count has reached the effective capacity
        logic match;    // read word equals the search target
        logic idx_zero; // scan index is at the bottom entry
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/iss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/iss_ctrl.sv
// Controller for the integer stack: sequences each request, drives the
// datapath commands and owns the input stall and output valid.
// Depends on iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iss_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [iss_pkg::REQ_W-1:0] i_req_type,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    input  wire iss_pkg::t_sts             i_sts,
    output iss_pkg::t_cmd                  o_cmd
);

    iss_pkg::t_state r_state;
    iss_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;
    logic            w_accept;
    iss_pkg::t_req   w_req;

    assign w_req      = iss_pkg::t_req'(i_req_type);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = (r_state == iss_pkg::S_IDLE) && i_in_valid && w_out_free;
    assign o_in_stall = !((r_state == iss_pkg::S_IDLE) && w_out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iss_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        iss_pkg::REQ_POP: begin
                            if (!i_sts.empty) n_state = iss_pkg::S_READ_POP;
                        end
                        iss_pkg::REQ_PEEK: begin
                            if (!i_sts.empty) n_state = iss_pkg::S_READ_PEEK;
                        end
                        iss_pkg::REQ_SEARCH: begin
                            if (!i_sts.empty) n_state = iss_pkg::S_SCAN;
                        end
                        default: n_state = iss_pkg::S_IDLE;
                    endcase
                end
            end
            iss_pkg::S_READ_POP,
            iss_pkg::S_READ_PEEK: n_state = iss_pkg::S_IDLE;
            iss_pkg::S_SCAN: begin
                if (i_sts.match || i_sts.idx_zero) n_state = iss_pkg::S_IDLE;
            end
            default: n_state = iss_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_sel    = iss_pkg::RES_PLAIN;
        o_cmd.res_status = iss_pkg::ST_OK;
        unique case (r_state)
            iss_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        iss_pkg::REQ_PUSH: begin
                            o_cmd.res_load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.res_status = iss_pkg::ST_FULL;
                            end else begin
                                o_cmd.ram_wr    = 1'b1;
                                o_cmd.count_inc = 1'b1;
                            end
                        end
                        iss_pkg::REQ_POP,
                        iss_pkg::REQ_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = iss_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.rd_top = 1'b1;
                            end
                        end
                        iss_pkg::REQ_CLEAR: begin
                            o_cmd.count_clr = 1'b1;
                            o_cmd.res_load  = 1'b1;
                        end
                        iss_pkg::REQ_SEARCH: begin
                            o_cmd.capture = 1'b1;
                            if (i_sts.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = iss_pkg::ST_NOTFOUND;
                            end else begin
                                o_cmd.rd_top = 1'b1;
                            end
                        end
                        // Unknown request: report state, change nothing
                        default: o_cmd.res_load = 1'b1;
                    endcase
                end
            end
            iss_pkg::S_READ_POP: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_sel   = iss_pkg::RES_RDDATA;
                o_cmd.count_dec = 1'b1;
            end
            iss_pkg::S_READ_PEEK: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = iss_pkg::RES_RDDATA;
            end
            iss_pkg::S_SCAN: begin
                if (i_sts.match) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = iss_pkg::RES_FOUND;
                end else if (i_sts.idx_zero) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = iss_pkg::ST_NOTFOUND;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            default: o_cmd.res_load = 1'b0;
        endcase
    end

    // Hold a stalled result, raise valid when a new one is loaded
    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.res_load;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iss_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.res_load)
        else $error("result loaded over a stalled transaction");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iss_pkg::S_READ_POP || r_state == iss_pkg::S_READ_PEEK)
        |=> (r_state == iss_pkg::S_IDLE))
        else $error("pop or peek did not finish after one read");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != iss_pkg::S_IDLE) |-> o_in_stall)
        else $error("input not stalled while a request is in progress");

endmodule

`default_nettype wire

// File: hdl/iss_dp.sv
// Datapath for the integer stack: entry count, capacity register, stack RAM,
// scan index, compare and the result registers.
// Depends on iss_pkg and iss_ram.
`timescale 1ns / 1ps
`default_nettype none

module iss_dp #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iss_pkg::t_cmd                 i_cmd,
    output iss_pkg::t_sts                      o_sts,
    input  wire logic                          i_cfg_write,
    input  wire logic [iss_pkg::CAP_W-1:0]     i_cfg_data,
    input  wire logic [iss_pkg::VALUE_W-1:0]   i_value,
    output logic      [iss_pkg::STATUS_W-1:0]  o_status,
    output logic      [iss_pkg::VALUE_W-1:0]   o_data,
    output logic      [iss_pkg::INDEX_W-1:0]   o_found_index,
    output logic      [iss_pkg::COUNT_W-1:0]   o_count,
    output logic                               o_is_empty,
    output logic                               o_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > iss_pkg::COUNT_W) ? CW : iss_pkg::COUNT_W;
    localparam int FW = (AW > iss_pkg::INDEX_W) ? AW : iss_pkg::INDEX_W;

    logic [iss_pkg::CAP_W-1:0]    r_capacity;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [AW-1:0]                r_scan_idx;
    logic [iss_pkg::VALUE_W-1:0]  r_target;
    logic [iss_pkg::VALUE_W-1:0]  w_rd_data;
    logic [AW-1:0]                w_rd_addr;
    logic [CW-1:0]                w_top_idx;
    logic [WW-1:0]                w_cap_ext;
    logic [WW-1:0]                w_cap_eff;
    logic [WW-1:0]                w_cnt_ext;
    logic [FW-1:0]                w_fidx_ext;

    logic [iss_pkg::STATUS_W-1:0] r_status;
    logic [iss_pkg::VALUE_W-1:0]  r_data;
    logic [iss_pkg::INDEX_W-1:0]  r_found_index;
    logic [CW-1:0]                r_res_count;
    logic                         r_is_empty;
    logic                         r_is_full;

    // Capacity above the store size saturates at the store size
    assign w_cap_ext = WW'(r_capacity);
    assign w_cap_eff = (w_cap_ext > WW'(DEPTH)) ? WW'(DEPTH) : w_cap_ext;

    assign w_top_idx = r_count - 1'b1;
    assign w_rd_addr = i_cmd.rd_top ? w_top_idx[AW-1:0] : (r_scan_idx - 1'b1);

    iss_ram #(
        .WIDTH (iss_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ram_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.count_clr) begin
            n_count = '0;
        end else if (i_cmd.count_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.count_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (WW'(r_count) >= w_cap_eff);
    assign o_sts.match    = (w_rd_data == r_target);
    assign o_sts.idx_zero = (r_scan_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= iss_pkg::CAP_RESET;
            r_count    <= '0;
        end else begin
            if (i_cfg_write) begin
                r_capacity <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_target <= i_value;
        end
        // After a top or next read the scan index names the entry whose word arrives next cycle
        if (i_cmd.rd_top) begin
            r_scan_idx <= w_top_idx[AW-1:0];
        end else if (i_cmd.rd_next) begin
            r_scan_idx <= r_scan_idx - 1'b1;
        end
    end

    assign w_fidx_ext = FW'(r_scan_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status    <= i_cmd.res_status;
            r_res_count <= n_count;
            r_is_empty  <= (n_count == '0);
            r_is_full   <= (WW'(n_count) >= w_cap_eff);
            unique case (i_cmd.res_sel)
                iss_pkg::RES_RDDATA: begin
                    r_data        <= w_rd_data;
                    r_found_index <= '0;
                end
                iss_pkg::RES_FOUND: begin
                    r_data        <= '0;
                    r_found_index <= w_fidx_ext[iss_pkg::INDEX_W-1:0];
                end
                default: begin
                    r_data        <= '0;
                    r_found_index <= '0;
                end
            endcase
        end
    end

    assign w_cnt_ext     = WW'(r_res_count);
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found_index = r_found_index;
    assign o_count       = w_cnt_ext[iss_pkg::COUNT_W-1:0];
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_count) <= WW'(DEPTH))
        else $error("entry count above store size");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ram_wr |-> (WW'(r_count) < w_cap_eff))
        else $error("push written with no room left");

endmodule

`default_nettype wire

// File: hdl/integer_stack_with_search_unit.sv
// Top level of the integer stack with search: joins controller and datapath.
// Depends on iss_pkg, iss_ctrl, iss_dp (and through it iss_ram).
//
// A LIFO store of signed 32-bit words, up to DEPTH entries and a programmable
// capacity, taking push, pop, peek, clear and search requests and returning
// one result per request with status, data, match index, count and flags.
// Requests are handled one at a time; push, clear and unknown codes need no
// RAM read, pop and peek make one read of the stack RAM, and search makes no
// read on an empty stack, otherwise it checks entries from the top down
// until a match or the bottom entry. Reads go through the single registered
// read port of the stack RAM, which yields one entry per cycle. The result
// sits in an output register; the input stalls while a request is in
// progress or while a finished result is stalled at the output. The RAM
// needs no clearing after reset. Write capacity only while idle; the
// configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module integer_stack_with_search_unit #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [iss_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [iss_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [iss_pkg::VALUE_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [iss_pkg::STATUS_W-1:0] o_status,
    output logic      [iss_pkg::VALUE_W-1:0]  o_data,
    output logic      [iss_pkg::INDEX_W-1:0]  o_found_index,
    output logic      [iss_pkg::COUNT_W-1:0]  o_count,
    output logic                              o_is_empty,
    output logic                              o_is_full
);

    iss_pkg::t_cmd w_cmd;
    iss_pkg::t_sts w_sts;
    logic          w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    iss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    iss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_write   (w_cfg_write),
        .i_cfg_data    (i_cfg_data),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

endmodule

`default_nettype wire

// File: tb/integer_stack_with_search_checker.sv
// Checker for the integer stack with search: watches the config, request and
// result channels, predicts each result and compares it field by field.
// Depends on iss_pkg for widths, request codes and status codes.
`timescale 1ns / 1ps

module integer_stack_with_search_checker
    import iss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [VALUE_W-1:0] i_data,
    input  logic [INDEX_W-1:0] i_found_index,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_is_empty,
    input  logic               i_is_full,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  data;
        logic [INDEX_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
        logic                is_full;
    } t_stack_result;

    logic [VALUE_W-1:0] word_mem [DEPTH];
    int                 held = 0;
    logic [CAP_W-1:0]   capacity_reg = CAP_RESET;
    t_stack_result      due_results [$];
    int                 fails = 0;
    int                 checked = 0;

    // Apply one request to the model stack and return the result it produces
    function automatic t_stack_result apply_request(input logic [REQ_W-1:0] req,
                                                    input logic [VALUE_W-1:0] word);
        t_stack_result res;
        int            cap_eff;
        bit            hit;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        // saturate capacity at the physical depth
        cap_eff = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
        case (req)
            REQ_PUSH: begin
                if (held >= cap_eff) begin
                    res.status = ST_FULL;
                end else begin
                    word_mem[held] = word;
                    held++;
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = word_mem[held-1];
                    if (req == REQ_POP) begin
                        held--;
                    end
                end
            end
            REQ_CLEAR: begin
                held = 0;
            end
            REQ_SEARCH: begin
                // scan from the top entry down, stop on the first match
                for (int i = held - 1; i >= 0 && !hit; i--) begin
                    if (word_mem[i] == word) begin
                        hit = 1'b1;
                        res.found_index = INDEX_W'(i);
                    end
                end
                if (!hit) begin
                    res.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        res.count    = COUNT_W'(held);
        res.is_empty = (held == 0);
        res.is_full  = (held >= cap_eff);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_stack_result want;
        if (!i_rst_n) begin
            held = 0;
            capacity_reg = CAP_RESET;
            due_results.delete();
        end else begin
            // compare before predicting: a result never belongs to a request
            // accepted at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result with no request outstanding, expected none",
                             $time);
                    $display("%0t: actual status %0d data 0x%0h count %0d",
                             $time, i_status, i_data, i_count);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", VALUE_W'(want.status), VALUE_W'(i_status));
                    check_field("data", want.data, i_data);
                    check_field("found_index", VALUE_W'(want.found_index),
                                VALUE_W'(i_found_index));
                    check_field("count", VALUE_W'(want.count), VALUE_W'(i_count));
                    check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(i_is_empty));
                    check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(i_is_full));
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                capacity_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(apply_request(i_req_type, i_value));
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: tb/integer_stack_with_search_unit_tb.sv
// Testbench top for the integer stack with search: clock, reset, request and
// capacity stimulus, result-side stall pattern and the final verdict.
// Depends on iss_pkg, integer_stack_with_search_unit and the stack checker.
`timescale 1ns / 1ps

module integer_stack_with_search_unit_tb;
    import iss_pkg::*;

    localparam logic [REQ_W-1:0]   REQ_RSVD_LO  = 3'd5;
    localparam logic [REQ_W-1:0]   REQ_RSVD_MID = 3'd6;
    localparam logic [REQ_W-1:0]   REQ_RSVD_HI  = 3'd7;
    localparam logic [VALUE_W-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] WORD_NEG1    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CAP_W-1:0]     cfg_data = CAP_RESET;
    logic                 in_valid = 1'b0;
    logic [REQ_W-1:0]     req_type = REQ_PUSH;
    logic [VALUE_W-1:0]   in_value = '0;
    logic                 out_stall = 1'b0;

    logic                 cfg_ready;
    logic                 in_stall;
    logic                 out_valid;
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   data;
    logic [INDEX_W-1:0]   found_index;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
    logic                 is_full;

    int fail_count;
    int pending;
    int checked;

    int          burst_left = 0;
    int          req_seen [8];
    int          settings_used = 1;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    logic [4:0]  ptn_cnt = '0;

    integer_stack_with_search_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_value       (in_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_data        (data),
        .o_found_index (found_index),
        .o_count       (count),
        .o_is_empty    (is_empty),
        .o_is_full     (is_full)
    );

    integer_stack_with_search_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_value       (in_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_data        (data),
        .i_found_index (found_index),
        .i_count       (count),
        .i_is_empty    (is_empty),
        .i_is_full     (is_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result-side stall: switch between patterns chosen at random
    always @(negedge i_clk) begin
        ptn_cnt <= ptn_cnt + 1'b1;
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: out_stall <= (ptn_cnt[2:0] < 3'd3);
            STALL_LONG:     out_stall <= (ptn_cnt < 5'd20);
            default:        out_stall <= 1'b0;
        endcase
    end

    // Drive one request and hold it until the unit accepts it
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] word);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        req_type <= req;
        in_value <= word;
        req_seen[req]++;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Write capacity only once every outstanding result has come back
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random requests with the given weights; values lean on a small pool so
    // searches hit, with extremes and full-range words mixed in
    task automatic run_phase(input int n, input int w_push, input int w_pop,
                             input int w_peek, input int w_clear, input int w_search,
                             input int w_odd);
        int               total;
        int               r;
        logic [REQ_W-1:0] req;
        logic [VALUE_W-1:0] word;
        total = w_push + w_pop + w_peek + w_clear + w_search + w_odd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, total - 1);
            if (r < w_push) begin
                req = REQ_PUSH;
            end else if (r < w_push + w_pop) begin
                req = REQ_POP;
            end else if (r < w_push + w_pop + w_peek) begin
                req = REQ_PEEK;
            end else if (r < w_push + w_pop + w_peek + w_clear) begin
                req = REQ_CLEAR;
            end else if (r < total - w_odd) begin
                req = REQ_SEARCH;
            end else begin
                req = REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: word = VALUE_W'($urandom_range(0, 11)) - 32'd6;
                5: begin
                    case ($urandom_range(0, 3))
                        0:       word = WORD_MIN;
                        1:       word = WORD_MAX;
                        2:       word = '0;
                        default: word = WORD_NEG1;
                    endcase
                end
                default: word = $urandom();
            endcase
            send_req(req, word);
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty-stack cases, extremes, duplicates, reserved codes
        send_req(REQ_POP, '0);
        send_req(REQ_PEEK, '0);
        send_req(REQ_SEARCH, '0);
        send_req(REQ_PUSH, WORD_MIN);
        send_req(REQ_PUSH, WORD_MAX);
        send_req(REQ_PUSH, '0);
        send_req(REQ_PUSH, WORD_NEG1);
        send_req(REQ_PUSH, WORD_MIN);
        send_req(REQ_PEEK, '0);
        send_req(REQ_SEARCH, WORD_MIN);
        send_req(REQ_SEARCH, WORD_MAX);
        send_req(REQ_SEARCH, 32'd12345);
        send_req(REQ_RSVD_LO, $urandom());
        send_req(REQ_RSVD_MID, $urandom());
        send_req(REQ_RSVD_HI, $urandom());
        send_req(REQ_POP, '0);
        send_req(REQ_CLEAR, '0);
        send_req(REQ_POP, '0);

        // zero capacity: always full
        write_capacity('0);
        send_req(REQ_PUSH, 32'd1);
        send_req(REQ_PEEK, '0);
        send_req(REQ_SEARCH, 32'd1);

        write_capacity(9'd1);
        send_req(REQ_PUSH, 32'd7);
        send_req(REQ_PUSH, 32'd8);
        send_req(REQ_POP, '0);

        // fill to full depth, then shrink capacity under the held count
        write_capacity(CAP_RESET);
        run_phase(360, 78, 4, 4, 0, 12, 2);
        write_capacity(9'd17);
        run_phase(120, 30, 40, 10, 0, 18, 2);
        write_capacity(CAP_RESET);
        run_phase(200, 35, 25, 12, 3, 23, 2);
        write_capacity('0);
        run_phase(40, 30, 20, 15, 5, 25, 5);
        write_capacity(9'd1);
        run_phase(60, 35, 25, 15, 5, 17, 3);
        write_capacity(9'd255);
        run_phase(300, 75, 5, 5, 0, 13, 2);
        write_capacity(9'd5);
        run_phase(100, 40, 25, 10, 5, 17, 3);
        write_capacity(CAP_RESET);
        run_phase(100, 10, 60, 10, 0, 18, 2);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Requests: push %0d, pop %0d, peek %0d, clear %0d, search %0d, reserved %0d",
                 req_seen[REQ_PUSH], req_seen[REQ_POP], req_seen[REQ_PEEK],
                 req_seen[REQ_CLEAR], req_seen[REQ_SEARCH],
                 req_seen[REQ_RSVD_LO] + req_seen[REQ_RSVD_MID] + req_seen[REQ_RSVD_HI]);
        $display("Capacity settings used: %0d; results compared: %0d; failures: %0d",
                 settings_used, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
